>>> sv/gdrm_pkg.sv
// Package: shared types, constants and helper functions of the jet matcher.
`default_nettype none
package gdrm_pkg;

    localparam int MAX_REFS_DEF = 32;

    localparam int ETA_W    = 10;
    localparam int PHI_W    = 10;
    localparam int PT_W     = 14;
    localparam int SCORE_W  = 10;
    localparam int OP_W     = 2;
    localparam int RADIUS_W = 16;
    localparam int TAGTH_W  = 10;
    localparam int BARREL_W = 9;
    localparam int CAT_W    = 2;
    localparam int BIN_W    = 3;
    localparam int MIDX_W   = 5;
    localparam int SQE_W    = 20;
    localparam int SQP_W    = 17;
    localparam int DIST_W   = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;
    localparam int REF_W    = ETA_W + PHI_W + PT_W;

    localparam int PHI_FULL = 628;
    localparam int PHI_HALF = 314;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_MATCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BARREL = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd1600;
    localparam logic [TAGTH_W-1:0]  TAGTH_RST  = 10'd869;
    localparam logic [BARREL_W-1:0] BARREL_RST = 9'd130;

    localparam logic [CAT_W-1:0] CAT_TAG_BARREL   = 2'd0;
    localparam logic [CAT_W-1:0] CAT_TAG_ENDCAP   = 2'd1;
    localparam logic [CAT_W-1:0] CAT_LIGHT_BARREL = 2'd2;
    localparam logic [CAT_W-1:0] CAT_LIGHT_ENDCAP = 2'd3;

    localparam int NUM_EDGES = 8;
    localparam logic [BIN_W-1:0] BIN_NONE = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic locked;
    } scan_tag_t;

    function automatic logic [PT_W-1:0] bin_edge(input int i);
        logic [PT_W-1:0] e;
        unique case (i)
            0:       e = 14'd120;
            1:       e = 14'd200;
            2:       e = 14'd280;
            3:       e = 14'd400;
            4:       e = 14'd560;
            5:       e = 14'd800;
            6:       e = 14'd1000;
            default: e = 14'd1200;
        endcase
        return e;
    endfunction

    function automatic logic [BIN_W-1:0] pt_bin_of(input logic [PT_W-1:0] pt);
        logic [BIN_W-1:0] b;
        b = BIN_NONE;
        for (int i = NUM_EDGES - 2; i >= 0; i--) begin
            if (pt > bin_edge(i) && pt <= bin_edge(i + 1)) begin
                b = BIN_W'(i);
            end
        end
        return b;
    endfunction

endpackage
`default_nettype wire

>>> sv/gdrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module gdrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> sv/gdrm_dist.sv
// Two-stage squared delta-R pipeline with phi wrap.
`default_nettype none
module gdrm_dist #(
    parameter int ADDR_W = 5
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire gdrm_pkg::scan_tag_t               in_tag,
    input  wire logic [ADDR_W-1:0]                 in_idx,
    input  wire logic signed [gdrm_pkg::ETA_W-1:0] ref_eta,
    input  wire logic signed [gdrm_pkg::PHI_W-1:0] ref_phi,
    input  wire logic [gdrm_pkg::PT_W-1:0]         ref_pt,
    input  wire logic signed [gdrm_pkg::ETA_W-1:0] item_eta,
    input  wire logic signed [gdrm_pkg::PHI_W-1:0] item_phi,
    output gdrm_pkg::scan_tag_t                    out_tag,
    output logic [ADDR_W-1:0]                      out_idx,
    output logic [gdrm_pkg::PT_W-1:0]              out_pt,
    output logic [gdrm_pkg::SQE_W-1:0]             out_sq_eta,
    output logic [gdrm_pkg::SQP_W-1:0]             out_sq_phi,
    output logic                                   busy
);

    gdrm_pkg::scan_tag_t                  tag_a_reg, tag_b_reg;
    logic [ADDR_W-1:0]                    idx_a_reg, idx_b_reg;
    logic [gdrm_pkg::PT_W-1:0]            pt_a_reg, pt_b_reg;
    logic signed [gdrm_pkg::ETA_W:0]      de_reg, de_next;
    logic signed [gdrm_pkg::PHI_W-1:0]    dp_reg, dp_next;
    logic [gdrm_pkg::SQE_W-1:0]           sqe_reg, sqe_next;
    logic [gdrm_pkg::SQP_W-1:0]           sqp_reg, sqp_next;
    logic signed [11:0]                   dp_raw, dp_wrap;
    logic signed [21:0]                   prod_e;
    logic signed [19:0]                   prod_p;

    always_comb begin
        de_next = {item_eta[gdrm_pkg::ETA_W-1], item_eta} - {ref_eta[gdrm_pkg::ETA_W-1], ref_eta};
        dp_raw  = {{2{item_phi[gdrm_pkg::PHI_W-1]}}, item_phi}
                - {{2{ref_phi[gdrm_pkg::PHI_W-1]}}, ref_phi};
        priority if (dp_raw > 12'(3 * gdrm_pkg::PHI_HALF)) begin
            dp_wrap = dp_raw - 12'(2 * gdrm_pkg::PHI_FULL);
        end else if (dp_raw > 12'(gdrm_pkg::PHI_HALF)) begin
            dp_wrap = dp_raw - 12'(gdrm_pkg::PHI_FULL);
        end else if (dp_raw < -12'(3 * gdrm_pkg::PHI_HALF)) begin
            dp_wrap = dp_raw + 12'(2 * gdrm_pkg::PHI_FULL);
        end else if (dp_raw < -12'(gdrm_pkg::PHI_HALF)) begin
            dp_wrap = dp_raw + 12'(gdrm_pkg::PHI_FULL);
        end else begin
            dp_wrap = dp_raw;
        end
        dp_next = dp_wrap[gdrm_pkg::PHI_W-1:0];
    end

    always_comb begin
        prod_e   = de_reg * de_reg;
        prod_p   = dp_reg * dp_reg;
        sqe_next = prod_e[gdrm_pkg::SQE_W-1:0];
        sqp_next = prod_p[gdrm_pkg::SQP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end else begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
        end
        idx_a_reg <= in_idx;
        idx_b_reg <= idx_a_reg;
        pt_a_reg  <= ref_pt;
        pt_b_reg  <= pt_a_reg;
        de_reg    <= de_next;
        dp_reg    <= dp_next;
        sqe_reg   <= sqe_next;
        sqp_reg   <= sqp_next;
    end

    assign out_tag    = tag_b_reg;
    assign out_idx    = idx_b_reg;
    assign out_pt     = pt_b_reg;
    assign out_sq_eta = sqe_reg;
    assign out_sq_phi = sqp_reg;
    assign busy       = tag_a_reg.valid;

endmodule
`default_nettype wire

>>> sv/greedy_delta_r_jet_matcher_core.sv
// Top level: greedy delta-R jet matcher with reference store, scan and result word.
// Words are accepted only in idle. Load and clear words update the store when accepted;
// a match word starts a scan of the stored references, and the result word is registered
// once the output is free; the next word is taken only after the result is registered.
// The scan is paced by the single read port of the reference RAM, one entry a cycle.
// Active-low sync reset clears count, lock bits, valid flags, state; presets config.
`default_nettype none
module greedy_delta_r_jet_matcher_core #(
    parameter int MAX_REFS = gdrm_pkg::MAX_REFS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // eta[9:0], phi[19:10], pt[33:20], tag_score[43:34], zero pad
    input  wire logic [gdrm_pkg::S_DATA_W-1:0]       s_tdata,
    // operation[1:0]
    input  wire logic [gdrm_pkg::OP_W-1:0]           s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // matched[0], match_index[5:1], reference_pt[19:6], reco_pt[33:20],
    // category[35:34], pt_bin[38:36], zero pad
    output logic [gdrm_pkg::M_DATA_W-1:0]            m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gdrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gdrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = MAX_REFS > 1 ? $clog2(MAX_REFS) : 1;
    localparam int CNT_W  = $clog2(MAX_REFS + 1);

    gdrm_pkg::state_t state_reg, state_next;

    logic [gdrm_pkg::RADIUS_W-1:0] radius_reg;
    logic [gdrm_pkg::TAGTH_W-1:0]  tagth_reg;
    logic [gdrm_pkg::BARREL_W-1:0] barrel_reg;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [MAX_REFS-1:0] locked_reg, locked_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                v1_reg;
    logic [ADDR_W-1:0]   idx1_reg;

    logic signed [gdrm_pkg::ETA_W-1:0] item_eta_reg;
    logic signed [gdrm_pkg::PHI_W-1:0] item_phi_reg;
    logic [gdrm_pkg::PT_W-1:0]         item_pt_reg;
    logic [gdrm_pkg::CAT_W-1:0]        cat_reg;
    logic [gdrm_pkg::BIN_W-1:0]        bin_reg;

    logic                         found_reg, found_next;
    logic [ADDR_W-1:0]            best_idx_reg, best_idx_next;
    logic [gdrm_pkg::DIST_W-1:0]  best_d_reg, best_d_next;
    logic [gdrm_pkg::PT_W-1:0]    best_pt_reg, best_pt_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [gdrm_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [gdrm_pkg::OP_W-1:0]         in_op;
    logic signed [gdrm_pkg::ETA_W-1:0] in_eta;
    logic signed [gdrm_pkg::PHI_W-1:0] in_phi;
    logic [gdrm_pkg::PT_W-1:0]         in_pt;
    logic [gdrm_pkg::SCORE_W-1:0]      in_score;
    logic [gdrm_pkg::ETA_W-1:0]        abs_eta;
    logic [gdrm_pkg::CAT_W-1:0]        cat_next;

    logic                          accept, do_load, do_match, do_clear;
    logic                          issue_en, scan_done, out_load;
    logic                          ram_we;
    logic [ADDR_W-1:0]             wr_addr;
    logic [gdrm_pkg::REF_W-1:0]    ram_wdata, ram_rdata;

    gdrm_pkg::scan_tag_t           tag1, tag3;
    logic [ADDR_W-1:0]             idx3;
    logic [gdrm_pkg::PT_W-1:0]     pt3;
    logic [gdrm_pkg::SQE_W-1:0]    sq_eta3;
    logic [gdrm_pkg::SQP_W-1:0]    sq_phi3;
    logic [gdrm_pkg::DIST_W-1:0]   dist3;
    logic                          dist_busy;
    logic [ADDR_W+gdrm_pkg::MIDX_W-1:0] midx_ext;
    logic [gdrm_pkg::M_DATA_W-1:0] out_word;

    // input word unpacking
    assign in_op    = s_tuser;
    assign in_eta   = s_tdata[9:0];
    assign in_phi   = s_tdata[19:10];
    assign in_pt    = s_tdata[33:20];
    assign in_score = s_tdata[43:34];

    assign accept   = s_tvalid && s_tready;
    assign do_load  = accept && (in_op == gdrm_pkg::OP_LOAD);
    assign do_match = accept && (in_op == gdrm_pkg::OP_MATCH);
    assign do_clear = accept && (in_op == gdrm_pkg::OP_CLEAR);

    assign abs_eta = in_eta[gdrm_pkg::ETA_W-1] ? gdrm_pkg::ETA_W'(-in_eta) : in_eta;

    always_comb begin
        if (in_score > tagth_reg) begin
            cat_next = (abs_eta < {1'b0, barrel_reg}) ? gdrm_pkg::CAT_TAG_BARREL
                                                     : gdrm_pkg::CAT_TAG_ENDCAP;
        end else begin
            cat_next = (abs_eta < {1'b0, barrel_reg}) ? gdrm_pkg::CAT_LIGHT_BARREL
                                                     : gdrm_pkg::CAT_LIGHT_ENDCAP;
        end
    end

    // reference store
    assign ram_we    = do_load && (count_reg < CNT_W'(MAX_REFS));
    assign wr_addr   = count_reg[ADDR_W-1:0];
    assign ram_wdata = {in_pt, in_phi, in_eta};

    gdrm_ram #(
        .WIDTH (gdrm_pkg::REF_W),
        .DEPTH (MAX_REFS)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (ram_wdata),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign tag1.valid  = v1_reg;
    assign tag1.locked = locked_reg[idx1_reg];

    gdrm_dist #(
        .ADDR_W (ADDR_W)
    ) u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_tag     (tag1),
        .in_idx     (idx1_reg),
        .ref_eta    (ram_rdata[9:0]),
        .ref_phi    (ram_rdata[19:10]),
        .ref_pt     (ram_rdata[33:20]),
        .item_eta   (item_eta_reg),
        .item_phi   (item_phi_reg),
        .out_tag    (tag3),
        .out_idx    (idx3),
        .out_pt     (pt3),
        .out_sq_eta (sq_eta3),
        .out_sq_phi (sq_phi3),
        .busy       (dist_busy)
    );

    assign dist3 = {1'b0, sq_eta3} + {{(gdrm_pkg::DIST_W - gdrm_pkg::SQP_W){1'b0}}, sq_phi3};

    // best-candidate tracking
    always_comb begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        best_pt_next  = best_pt_reg;
        if (do_match) begin
            found_next    = 1'b0;
            best_idx_next = '0;
            best_d_next   = '0;
            best_pt_next  = '0;
        end else if (tag3.valid && !tag3.locked
                     && dist3 < {{(gdrm_pkg::DIST_W - gdrm_pkg::RADIUS_W){1'b0}}, radius_reg}
                     && (!found_reg || dist3 < best_d_reg)) begin
            found_next    = 1'b1;
            best_idx_next = idx3;
            best_d_next   = dist3;
            best_pt_next  = pt3;
        end
    end

    assign scan_done = (issue_reg >= count_reg) && !v1_reg && !dist_busy && !tag3.valid;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gdrm_pkg::ST_IDLE: if (do_match) state_next = gdrm_pkg::ST_SCAN;
            gdrm_pkg::ST_SCAN: if (scan_done) state_next = gdrm_pkg::ST_DONE;
            gdrm_pkg::ST_DONE: if (out_load) state_next = gdrm_pkg::ST_IDLE;
            default:           state_next = gdrm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        issue_en = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            gdrm_pkg::ST_IDLE: s_tready = 1'b1;
            gdrm_pkg::ST_SCAN: issue_en = (issue_reg < count_reg);
            gdrm_pkg::ST_DONE: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_comb begin
        issue_next = issue_reg;
        if (do_match) begin
            issue_next = '0;
        end else if (issue_en) begin
            issue_next = issue_reg + 1'b1;
        end
    end

    always_comb begin
        count_next  = count_reg;
        locked_next = locked_reg;
        if (do_clear) begin
            count_next  = '0;
            locked_next = '0;
        end else if (ram_we) begin
            count_next           = count_reg + 1'b1;
            locked_next[wr_addr] = 1'b0;
        end else if (out_load && found_reg) begin
            locked_next[best_idx_reg] = 1'b1;
        end
    end

    assign midx_ext = {{gdrm_pkg::MIDX_W{1'b0}}, best_idx_reg};

    always_comb begin
        out_word        = '0;
        out_word[0]     = found_reg;
        out_word[5:1]   = midx_ext[gdrm_pkg::MIDX_W-1:0];
        out_word[19:6]  = best_pt_reg;
        out_word[33:20] = item_pt_reg;
        out_word[35:34] = cat_reg;
        out_word[38:36] = bin_reg;
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= gdrm_pkg::ST_IDLE;
            radius_reg   <= gdrm_pkg::RADIUS_RST;
            tagth_reg    <= gdrm_pkg::TAGTH_RST;
            barrel_reg   <= gdrm_pkg::BARREL_RST;
            count_reg    <= '0;
            locked_reg   <= '0;
            issue_reg    <= '0;
            v1_reg       <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            locked_reg   <= locked_next;
            issue_reg    <= issue_next;
            v1_reg       <= issue_en;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    gdrm_pkg::CFG_RADIUS: radius_reg <= cfg_data;
                    gdrm_pkg::CFG_TAGTH:  tagth_reg  <= cfg_data[gdrm_pkg::TAGTH_W-1:0];
                    gdrm_pkg::CFG_BARREL: barrel_reg <= cfg_data[gdrm_pkg::BARREL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg     <= issue_reg[ADDR_W-1:0];
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        best_pt_reg  <= best_pt_next;
        if (do_match) begin
            item_eta_reg <= in_eta;
            item_phi_reg <= in_phi;
            item_pt_reg  <= in_pt;
            cat_reg      <= cat_next;
            bin_reg      <= gdrm_pkg::pt_bin_of(in_pt);
        end
        if (out_load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

>>> sv/gdrm_checker.sv
// Port-level checker for the jet matcher, bound to the top level.
`default_nettype none
module gdrm_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [gdrm_pkg::M_DATA_W-1:0]   m_tdata
);

    // result word holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // no result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // unmatched word carries zero index and zero reference pt
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[19:1] == '0)
        else $error("unmatched word with index or reference pt");

    // low reco pt lies below the first bin
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:20] <= 14'd120 |-> m_tdata[38:36] == gdrm_pkg::BIN_NONE)
        else $error("pt bin wrong for low pt");

endmodule

bind greedy_delta_r_jet_matcher_core gdrm_checker u_gdrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
